/* rtl/core/xbf_pkg.sv */
// xbf_pkg: shared types and constants for the xmodem block framer
// no dependencies; imported by every module in rtl/core
`timescale 1ns / 1ps
`default_nettype none

package xbf_pkg;

	localparam int unsigned PAYLOAD_LEN = 128;
	localparam int unsigned POS_W       = $clog2(PAYLOAD_LEN);
	localparam int unsigned QDEPTH      = 4;
	localparam int unsigned QPTR_W      = $clog2(QDEPTH);
	localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_PAD  = 2'd1;
	localparam logic [1:0] CMD_END  = 2'd2;

	localparam logic [7:0]  SOH_BYTE  = 8'h01;
	localparam logic [7:0]  EOT_BYTE  = 8'h04;
	localparam logic [7:0]  FILL_BYTE = 8'h1A;
	localparam logic [15:0] CRC_POLY  = 16'h1021;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_of_run;
	} out_item_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic       is_eot;
		logic       opens;
		logic       closes;
		logic       crc_trailer;
		logic [7:0] blk_num;
		logic [7:0] data;
		logic [7:0] trail_hi;
		logic [7:0] trail_lo;
	} job_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

/* rtl/core/xbf_front.sv */
// xbf_front: accepts input items, keeps block number, position, sum and crc
// depends on xbf_pkg; pushes one job per data, pad or end item to xbf_queue
`timescale 1ns / 1ps
`default_nettype none

module xbf_front
	import xbf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	input  wire q_stat_t  q_stat,
	output logic          push,
	output job_t          push_job
);

	logic             crc_mode_q;
	logic [7:0]       blk_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [15:0]      crc_q;

	logic        accept;
	logic        opens;
	logic        closes;
	logic [7:0]  data;
	logic [7:0]  blk_new;
	logic [7:0]  new_sum;
	logic [15:0] new_crc;

	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		data    = (in_data.command == CMD_PAD) ? FILL_BYTE : in_data.payload_byte;
		opens   = (pos_q == '0);
		closes  = (pos_q == POS_W'(PAYLOAD_LEN - 1));
		blk_new = opens ? blk_q + 8'd1 : blk_q;
		new_sum = (opens ? 8'd0 : sum_q) + data;
		new_crc = crc_add(opens ? 16'd0 : crc_q, data);
	end

	always_comb begin
		push_job.is_eot      = (in_data.command == CMD_END);
		push_job.opens       = opens;
		push_job.closes      = closes;
		push_job.crc_trailer = crc_mode_q;
		push_job.blk_num     = blk_new;
		push_job.data        = data;
		push_job.trail_hi    = crc_mode_q ? new_crc[15:8] : new_sum;
		push_job.trail_lo    = new_crc[7:0];
		// the unused command code makes no result
		push = accept && (in_data.command == CMD_DATA || in_data.command == CMD_PAD
			|| in_data.command == CMD_END);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_mode_q <= 1'b1;
		end else if (cfg_we) begin
			crc_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q <= '0;
			pos_q <= '0;
			sum_q <= '0;
			crc_q <= '0;
		end else if (accept) begin
			unique case (in_data.command)
				CMD_END: begin
					blk_q <= '0;
					pos_q <= '0;
					sum_q <= '0;
					crc_q <= '0;
				end
				CMD_DATA, CMD_PAD: begin
					blk_q <= blk_new;
					if (closes) begin
						pos_q <= '0;
						sum_q <= '0;
						crc_q <= '0;
					end else begin
						pos_q <= pos_q + POS_W'(1);
						sum_q <= new_sum;
						crc_q <= new_crc;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/xbf_queue.sv */
// xbf_queue: short job queue between front and back
// depends on xbf_pkg; register array with read and write pointers
`timescale 1ns / 1ps
`default_nettype none

module xbf_queue
	import xbf_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire job_t    push_job,
	input  wire logic    pop,
	output job_t         head,
	output q_stat_t      q_stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/xbf_back.sv */
// xbf_back: expands each job into framed bytes, one per cycle while out_ready allows
// depends on xbf_pkg; pops jobs from xbf_queue, drives the output register
`timescale 1ns / 1ps
`default_nettype none

module xbf_back
	import xbf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire job_t     head,
	input  wire q_stat_t  q_stat,
	output logic          pop,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);

	typedef enum logic [2:0] {
		PH_SOH,
		PH_NUM,
		PH_CMP,
		PH_DATA,
		PH_TR0,
		PH_TR1,
		PH_EOT
	} phase_t;

	phase_t    phase_q;
	job_t      cur_q;
	logic      cur_valid_q;
	out_item_t out_q;
	logic      out_valid_q;

	job_t      job;
	phase_t    ph;
	phase_t    ph_next;
	logic      load;
	logic      emit;
	logic      last;
	logic [7:0] byte_val;

	always_comb begin
		job = cur_valid_q ? cur_q : head;
		if (cur_valid_q) begin
			ph = phase_q;
		end else if (head.is_eot) begin
			ph = PH_EOT;
		end else if (head.opens) begin
			ph = PH_SOH;
		end else begin
			ph = PH_DATA;
		end

		load = !out_valid_q || out_ready;
		emit = load && (cur_valid_q || !q_stat.empty);

		last     = 1'b0;
		ph_next  = ph;
		byte_val = job.data;
		unique case (ph)
			PH_SOH: begin
				byte_val = SOH_BYTE;
				ph_next  = PH_NUM;
			end
			PH_NUM: begin
				byte_val = job.blk_num;
				ph_next  = PH_CMP;
			end
			PH_CMP: begin
				byte_val = ~job.blk_num;
				ph_next  = PH_DATA;
			end
			PH_DATA: begin
				byte_val = job.data;
				ph_next  = PH_TR0;
				last     = !job.closes;
			end
			PH_TR0: begin
				byte_val = job.trail_hi;
				ph_next  = PH_TR1;
				last     = !job.crc_trailer;
			end
			PH_TR1: begin
				byte_val = job.trail_lo;
				last     = 1'b1;
			end
			PH_EOT: begin
				byte_val = EOT_BYTE;
				last     = 1'b1;
			end
			default: begin
				last = 1'b1;
			end
		endcase

		// the head is taken over as soon as its first byte goes out
		pop = emit && !cur_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SOH;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				out_q.tx_byte     <= byte_val;
				out_q.last_of_run <= last;
				phase_q           <= ph_next;
				if (last) begin
					cur_valid_q <= 1'b0;
				end else begin
					cur_valid_q <= 1'b1;
					if (!cur_valid_q) begin
						cur_q <= head;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/xmodem_block_framer.sv */
// xmodem_block_framer: frames payload bytes into xmodem blocks with sum or crc-16 trailer
// accepted items go into the job queue; their bytes leave through the output register
// throughput: one result byte per cycle while a job waits and out_ready allows; an item
//   gives one byte, a block opener four, a closer two or three (output port bound)
// a four-entry job queue lets input keep flowing while block overhead drains
// reset: asynchronous, clears numbering, position, sum, crc and queue; crc mode set to 1
`timescale 1ns / 1ps
`default_nettype none

module xmodem_block_framer
	import xbf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata
);

	q_stat_t q_stat;
	logic    push;
	job_t    push_job;
	logic    pop;
	job_t    head;

	xbf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	xbf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	xbf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
